// ===== rtl/rbo_pkg.sv =====
// Shared types and constants for the region bounding box overlap block.
// Used by rbo_ctrl, rbo_datapath and the region_bbox_overlap_ratio top level.
`default_nettype none

package rbo_pkg;

  // Number formats
  localparam int COORD_FRAC_BITS = 4;
  localparam int RATIO_FRAC_BITS = 16;
  localparam int COORD_W         = 16;
  localparam int RATIO_W         = 17;
  localparam int HALF_PIX        = 1 << (COORD_FRAC_BITS - 1);

  // Internal widths: widened edges are signed, spans and areas unsigned
  localparam int EDGE_W  = COORD_W + 2;
  localparam int SPAN_W  = COORD_W + 1;
  localparam int AREA_W  = 2 * SPAN_W;
  localparam int UNION_W = AREA_W + 1;
  localparam int REM_W   = UNION_W + 1;

  // Restoring division: one quotient bit per cycle
  localparam int DIV_ITERS = RATIO_FRAC_BITS + 1;
  localparam int QUOT_W    = DIV_ITERS;
  localparam int CNT_W     = $clog2(DIV_ITERS);

  // Port packing
  localparam int OP_W        = 2;
  localparam int IN_DATA_W   = 6 * COORD_W;
  localparam int OUT_BITS    = 2 * RATIO_W + 2;
  localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } rbo_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } rbo_state_t;

  // Controller to datapath
  typedef struct packed {
    logic pix_upd;
    logic clear;
    logic q_load;
    logic edge_en;
    logic mul_en;
    logic sum_en;
    logic div_step;
    logic div_first;
    logic out_load;
  } rbo_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } rbo_stat_t;

endpackage

`default_nettype wire

// ===== rtl/rbo_ctrl.sv =====
// Sequencer for the overlap block: takes requests and steps a query through
// edge, multiply, sum and divide phases. Depends on rbo_pkg.
`default_nettype none

module rbo_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rbo_pkg::rbo_op_t  in_op,
  input  wire rbo_pkg::rbo_stat_t stat,
  output rbo_pkg::rbo_cmd_t      cmd
);
  import rbo_pkg::*;

  rbo_state_t       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  // State and iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        // Take no request while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          case (in_op)
            OP_ADD:   cmd.pix_upd = 1'b1;
            OP_CLEAR: cmd.clear   = 1'b1;
            OP_QUERY: begin
              cmd.q_load = 1'b1;
              state_next = ST_EDGE;
            end
            default: ;
          endcase
        end
      end
      ST_EDGE: begin
        cmd.edge_en = 1'b1;
        state_next  = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt == '0);
        if (cnt == CNT_W'(DIV_ITERS - 1)) begin
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DONE: begin
        // Hold the result until the output register frees up
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/rbo_datapath.sv =====
// Datapath for the overlap block: region box registers, intersection edges,
// area multipliers, two bit-serial dividers and the output register.
// Depends on rbo_pkg.
`default_nettype none

module rbo_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire rbo_pkg::rbo_cmd_t              cmd,
  output rbo_pkg::rbo_stat_t                  stat,
  input  wire logic [rbo_pkg::COORD_W-1:0]    pixel_x,
  input  wire logic [rbo_pkg::COORD_W-1:0]    pixel_y,
  input  wire logic [rbo_pkg::COORD_W-1:0]    query_min_x,
  input  wire logic [rbo_pkg::COORD_W-1:0]    query_min_y,
  input  wire logic [rbo_pkg::COORD_W-1:0]    query_max_x,
  input  wire logic [rbo_pkg::COORD_W-1:0]    query_max_y,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [rbo_pkg::RATIO_W-1:0]         overlap_union_ratio,
  output logic [rbo_pkg::RATIO_W-1:0]         overlap_min_ratio,
  output logic                                region_empty,
  output logic                                boxes_overlap
);
  import rbo_pkg::*;

  localparam logic [EDGE_W-1:0] HALF_E = EDGE_W'(HALF_PIX);

  // Region box state
  logic [COORD_W-1:0] box_left, box_top, box_right, box_bottom;
  logic               has_pixels, box_frozen;

  // Latched query
  logic [COORD_W-1:0] q_l, q_t, q_r, q_b;

  // Edge stage results
  logic              e_empty, e_overlap;
  logic [SPAN_W-1:0] iw, ih, rw, rh, qw, qh;

  // Area stage results
  logic [AREA_W-1:0] a_int, a_reg, a_qry;

  // Divider state
  logic [UNION_W-1:0] den_u;
  logic [AREA_W-1:0]  den_m;
  logic               zero_u, zero_m;
  logic [REM_W-1:0]   rem_u, rem_m;
  logic [QUOT_W-1:0]  quo_u, quo_m;

  // Combinational edge logic
  logic signed [EDGE_W-1:0] rl, rt, rr, rb, ql, qt, qr, qb;
  logic signed [EDGE_W-1:0] il, it, ir, ib;
  logic        [EDGE_W-1:0] d_iw, d_ih, d_rw, d_rh, d_qw, d_qh;

  // Divider step logic
  logic [REM_W-1:0] t_u, t_m, dm_ext, du_ext;
  logic             ge_u, ge_m;

  // Union sum
  logic [UNION_W-1:0] union_sum;

  // Grow or clear the region box
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      box_left   <= '1;
      box_top    <= '1;
      box_right  <= '0;
      box_bottom <= '0;
      has_pixels <= 1'b0;
      box_frozen <= 1'b0;
    end else begin
      if (cmd.pix_upd && !box_frozen) begin
        if (pixel_x < box_left)   box_left   <= pixel_x;
        if (pixel_x > box_right)  box_right  <= pixel_x;
        if (pixel_y < box_top)    box_top    <= pixel_y;
        if (pixel_y > box_bottom) box_bottom <= pixel_y;
        has_pixels <= 1'b1;
      end
      if (cmd.q_load && has_pixels) begin
        box_frozen <= 1'b1;
      end
    end
  end

  // Latch the query box
  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      q_l <= query_min_x;
      q_t <= query_min_y;
      q_r <= query_max_x;
      q_b <= query_max_y;
    end
  end

  // Widen the region by half a pixel and intersect with the query
  always_comb begin
    rl = $signed({2'b00, box_left})   - $signed(HALF_E);
    rt = $signed({2'b00, box_top})    - $signed(HALF_E);
    rr = $signed({2'b00, box_right})  + $signed(HALF_E);
    rb = $signed({2'b00, box_bottom}) + $signed(HALF_E);
    ql = $signed({2'b00, q_l});
    qt = $signed({2'b00, q_t});
    qr = $signed({2'b00, q_r});
    qb = $signed({2'b00, q_b});
    il = (rl > ql) ? rl : ql;
    it = (rt > qt) ? rt : qt;
    ir = (rr < qr) ? rr : qr;
    ib = (rb < qb) ? rb : qb;
    d_iw = ir - il;
    d_ih = ib - it;
    d_rw = rr - rl;
    d_rh = rb - rt;
    d_qw = qr - ql;
    d_qh = qb - qt;
  end

  // Register edge results
  always_ff @(posedge clk) begin
    if (cmd.edge_en) begin
      e_empty   <= !has_pixels;
      e_overlap <= has_pixels && !(il > ir) && !(it > ib);
      iw <= d_iw[SPAN_W-1:0];
      ih <= d_ih[SPAN_W-1:0];
      rw <= d_rw[SPAN_W-1:0];
      rh <= d_rh[SPAN_W-1:0];
      qw <= d_qw[SPAN_W-1:0];
      qh <= d_qh[SPAN_W-1:0];
    end
  end

  // Areas
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      a_int <= {{(AREA_W - SPAN_W){1'b0}}, iw} * {{(AREA_W - SPAN_W){1'b0}}, ih};
      a_reg <= {{(AREA_W - SPAN_W){1'b0}}, rw} * {{(AREA_W - SPAN_W){1'b0}}, rh};
      a_qry <= {{(AREA_W - SPAN_W){1'b0}}, qw} * {{(AREA_W - SPAN_W){1'b0}}, qh};
    end
  end

  assign union_sum = {1'b0, a_reg} + {1'b0, a_qry} - {1'b0, a_int};

  // Divider step: shift, compare, subtract
  always_comb begin
    du_ext = {1'b0, den_u};
    dm_ext = {{(REM_W - AREA_W){1'b0}}, den_m};
    t_u  = cmd.div_first ? rem_u : {rem_u[REM_W-2:0], 1'b0};
    t_m  = cmd.div_first ? rem_m : {rem_m[REM_W-2:0], 1'b0};
    ge_u = (t_u >= du_ext);
    ge_m = (t_m >= dm_ext);
  end

  // Load divisors, then advance one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      den_u  <= union_sum;
      den_m  <= (a_reg < a_qry) ? a_reg : a_qry;
      zero_u <= (union_sum == '0);
      zero_m <= (a_reg == '0) || (a_qry == '0);
      rem_u  <= {{(REM_W - AREA_W){1'b0}}, a_int};
      rem_m  <= {{(REM_W - AREA_W){1'b0}}, a_int};
      quo_u  <= '0;
      quo_m  <= '0;
    end else if (cmd.div_step) begin
      rem_u <= ge_u ? (t_u - du_ext) : t_u;
      rem_m <= ge_m ? (t_m - dm_ext) : t_m;
      quo_u <= {quo_u[QUOT_W-2:0], ge_u};
      quo_m <= {quo_m[QUOT_W-2:0], ge_m};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      overlap_union_ratio <= (e_overlap && !zero_u) ? RATIO_W'(quo_u) : '0;
      overlap_min_ratio   <= (e_overlap && !zero_m) ? RATIO_W'(quo_m) : '0;
      region_empty        <= e_empty;
      boxes_overlap       <= e_overlap;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== rtl/region_bbox_overlap_ratio.sv =====
// Top level of the region bounding box overlap block: stream ports, field
// packing, rbo_ctrl and rbo_datapath. Depends on rbo_pkg.
//
//   channel  direction  payload
//   s_axis   in         tuser: operation; tdata: pixel and query coordinates
//   m_axis   out        tdata: two ratios and two flags, one per query
//
// Add-pixel, clear and ignored requests are taken back to back while idle.
// A query steps through edge, multiply, sum and divide phases, and no request
// is taken meanwhile; the bit-serial dividers produce one quotient bit a cycle.
// Synchronous reset empties the region and drops any pending result.
// A stalled result waits in the output register; new requests are still
// taken until a second query result needs that register.
`default_nettype none

module region_bbox_overlap_ratio (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // operation
  input  wire logic [rbo_pkg::OP_W-1:0]         s_axis_tuser,
  // pixel_x, pixel_y, query_min_x, query_min_y, query_max_x, query_max_y
  input  wire logic [rbo_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // overlap_union_ratio, overlap_min_ratio, region_empty, boxes_overlap, zero pad
  output logic [rbo_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);
  import rbo_pkg::*;

  rbo_cmd_t           cmd;
  rbo_stat_t          stat;
  logic [RATIO_W-1:0] union_ratio, min_ratio;
  logic               empty_flag, overlap_flag;

  rbo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (rbo_op_t'(s_axis_tuser)),
    .stat     (stat),
    .cmd      (cmd)
  );

  rbo_datapath u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .stat                (stat),
    .pixel_x             (s_axis_tdata[0*COORD_W +: COORD_W]),
    .pixel_y             (s_axis_tdata[1*COORD_W +: COORD_W]),
    .query_min_x         (s_axis_tdata[2*COORD_W +: COORD_W]),
    .query_min_y         (s_axis_tdata[3*COORD_W +: COORD_W]),
    .query_max_x         (s_axis_tdata[4*COORD_W +: COORD_W]),
    .query_max_y         (s_axis_tdata[5*COORD_W +: COORD_W]),
    .out_valid           (m_axis_tvalid),
    .out_ready           (m_axis_tready),
    .overlap_union_ratio (union_ratio),
    .overlap_min_ratio   (min_ratio),
    .region_empty        (empty_flag),
    .boxes_overlap       (overlap_flag)
  );

  // Pack the result, first field lowest
  assign m_axis_tdata = {{(OUT_DATA_W - OUT_BITS){1'b0}},
                         overlap_flag, empty_flag, min_ratio, union_ratio};

endmodule

`default_nettype wire

// ===== rtl/rbo_checker.sv =====
// Port-level checks for region_bbox_overlap_ratio, attached by bind.
// Depends on the top level's port layout only.
`default_nettype none

module rbo_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Ratios never exceed one
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[16:0] <= 17'h10000) &&
                      (m_axis_tdata[33:17] <= 17'h10000))
    else $error("ratio above one");

  // Empty region gives no overlap and zero ratios
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[34] |->
      !m_axis_tdata[35] && (m_axis_tdata[33:0] == 34'd0))
    else $error("empty region with nonzero result");

  // No overlap gives zero ratios
  a_nolap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[35] |-> (m_axis_tdata[33:0] == 34'd0))
    else $error("ratios without overlap");

  // Nothing pending right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind region_bbox_overlap_ratio rbo_checker u_rbo_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/region_bbox_overlap_ratio_tb.sv =====
// Self-checking testbench for region_bbox_overlap_ratio: a directed table, then random
// pixel/query episodes, each result checked against an in-bench overlap predictor.
// Depends on rbo_pkg and the region_bbox_overlap_ratio RTL.
`default_nettype none

module region_bbox_overlap_ratio_tb;

  localparam int RANDOM_ITEMS = 500;
  localparam int CALM_ITEMS   = 60;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 4 * (rbo_pkg::RATIO_FRAC_BITS + 6);
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_MAX   = 10;
  localparam int CW           = rbo_pkg::COORD_W;
  localparam int RW           = rbo_pkg::RATIO_W;
  localparam logic [CW-1:0] COORD_MAX = '1;
  localparam logic [RW-1:0] RATIO_ONE = RW'(1) << rbo_pkg::RATIO_FRAC_BITS;
  // Unassigned operation code: the block drops it
  localparam logic [rbo_pkg::OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [rbo_pkg::OP_W-1:0] op;
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [CW-1:0] qlx;
    logic [CW-1:0] qty;
    logic [CW-1:0] qrx;
    logic [CW-1:0] qby;
  } overlap_req_t;

  typedef struct packed {
    logic [RW-1:0] union_ratio;
    logic [RW-1:0] min_ratio;
    logic          empty;
    logic          overlap;
  } overlap_res_t;

  typedef struct {
    overlap_req_t req;
    bit           fixed;
    overlap_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [rbo_pkg::OP_W-1:0] s_axis_tuser = '0;
  logic [rbo_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [rbo_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  // Predictor copy of the region box
  logic [CW-1:0] region_left, region_top, region_right, region_bottom;
  bit region_has_pixels, region_frozen;

  overlap_res_t ratio_expect_q[$];
  dir_row_t     dir_rows[$];

  int  fail_count = 0;
  int  useful_count = 0;
  int  results_seen = 0;
  int  overlap_hits = 0;
  int  empty_hits = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;

  region_bbox_overlap_ratio DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock, period 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [RW-1:0] ratio_fraction(input longint num, input longint den);
    if (den == 0) return '0;
    return RW'(((num << rbo_pkg::RATIO_FRAC_BITS) / den) & ((longint'(1) << RW) - 1));
  endfunction

  task automatic region_clear();
    region_left       = COORD_MAX;
    region_top        = COORD_MAX;
    region_right      = '0;
    region_bottom     = '0;
    region_has_pixels = 1'b0;
    region_frozen     = 1'b0;
  endtask

  // Advance the predictor by one request; flag whether it yields a result
  task automatic region_apply(input overlap_req_t req, output bit produced,
                              output overlap_res_t res);
    longint rl, rt, rr, rb, ql, qt, qr, qb, il, it, ir, ib;
    longint a_int, a_reg, a_qry, a_union, a_min;
    produced = 1'b0;
    res = '0;
    case (req.op)
      rbo_pkg::OP_ADD: begin
        if (!region_frozen) begin
          if (req.px < region_left)   region_left   = req.px;
          if (req.px > region_right)  region_right  = req.px;
          if (req.py < region_top)    region_top    = req.py;
          if (req.py > region_bottom) region_bottom = req.py;
          region_has_pixels = 1'b1;
        end
      end
      rbo_pkg::OP_CLEAR: region_clear();
      rbo_pkg::OP_QUERY: begin
        produced = 1'b1;
        res.empty = !region_has_pixels;
        if (region_has_pixels) begin
          region_frozen = 1'b1;
          // Widen the region by half a pixel on every side
          rl = longint'(region_left) - rbo_pkg::HALF_PIX;
          rt = longint'(region_top) - rbo_pkg::HALF_PIX;
          rr = longint'(region_right) + rbo_pkg::HALF_PIX;
          rb = longint'(region_bottom) + rbo_pkg::HALF_PIX;
          ql = longint'(req.qlx);
          qt = longint'(req.qty);
          qr = longint'(req.qrx);
          qb = longint'(req.qby);
          il = (rl > ql) ? rl : ql;
          it = (rt > qt) ? rt : qt;
          ir = (rr < qr) ? rr : qr;
          ib = (rb < qb) ? rb : qb;
          if (il <= ir && it <= ib) begin
            res.overlap = 1'b1;
            a_int   = (ir - il) * (ib - it);
            a_reg   = (rr - rl) * (rb - rt);
            a_qry   = (qr - ql) * (qb - qt);
            a_union = a_reg + a_qry - a_int;
            a_min   = (a_reg < a_qry) ? a_reg : a_qry;
            res.union_ratio = ratio_fraction(a_int, a_union);
            res.min_ratio   = ratio_fraction(a_int, a_min);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Offer one request, hold it until taken, then predict its result
  task automatic send_request(input overlap_req_t req, input bit fixed,
                              input overlap_res_t fixed_res);
    bit produced;
    overlap_res_t res;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s_axis_tuser  = req.op;
    s_axis_tdata  = {req.qby, req.qrx, req.qty, req.qlx, req.py, req.px};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (!(req.op == OP_NONE || (req.op == rbo_pkg::OP_ADD && region_frozen)))
      useful_count++;
    region_apply(req, produced, res);
    if (produced) ratio_expect_q.push_back(fixed ? fixed_res : res);
    if (useful_count == HOLD_AT) hold_req = 1'b1;
    @(negedge clk);
  endtask

  function automatic dir_row_t make_row(input logic [1:0] op, input int px, input int py,
                                        input int qlx, input int qty, input int qrx,
                                        input int qby, input bit fixed, input int ur,
                                        input int mr, input bit em, input bit ov);
    dir_row_t row;
    row.req   = '{op, CW'(px), CW'(py), CW'(qlx), CW'(qty), CW'(qrx), CW'(qby)};
    row.fixed = fixed;
    row.res   = '{RW'(ur), RW'(mr), em, ov};
    return row;
  endfunction

  function automatic logic [CW-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > int'(COORD_MAX)) return COORD_MAX;
    return CW'(v);
  endfunction

  function automatic int rand_off(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int pick_spread();
    case ($urandom_range(0, 3))
      0:       return 16;
      1:       return 256;
      2:       return 4096;
      default: return 40000;
    endcase
  endfunction

  // Receiver: random stalls, one long hold-off, none near the end
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      m_axis_tready = 1'b1;
    end
  end

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    overlap_res_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.union_ratio = m_axis_tdata[RW-1:0];
      got.min_ratio   = m_axis_tdata[2*RW-1:RW];
      got.empty       = m_axis_tdata[2*RW];
      got.overlap     = m_axis_tdata[2*RW+1];
      results_seen++;
      if (got.overlap) overlap_hits++;
      if (got.empty) empty_hits++;
      if (ratio_expect_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected result: union %0d min %0d empty %0d overlap %0d",
                   got.union_ratio, got.min_ratio, got.empty, got.overlap);
      end else begin
        want = ratio_expect_q.pop_front();
        if (got.union_ratio !== want.union_ratio || got.min_ratio !== want.min_ratio ||
            got.empty !== want.empty || got.overlap !== want.overlap) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("result %0d mismatch: exp union %0d min %0d empty %0d overlap %0d,",
                     results_seen, want.union_ratio, want.min_ratio, want.empty,
                     want.overlap, " got union %0d min %0d empty %0d overlap %0d",
                     got.union_ratio, got.min_ratio, got.empty, got.overlap);
        end
      end
    end
  end

  initial begin
    overlap_req_t req;
    int spread, qspread, cx, cy, mode, rand_start;
    logic [CW-1:0] swap;

    region_clear();

    // Directed rows; fixed expectations only where they are obvious
    dir_rows.push_back(make_row(rbo_pkg::OP_QUERY, 0, 0, 0, 0, 65535, 65535, 1, 0, 0, 1, 0));
    dir_rows.push_back(make_row(OP_NONE, 65535, 65535, 65535, 65535, 65535, 65535,
                                0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(rbo_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(rbo_pkg::OP_ADD, 65535, 65535, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(rbo_pkg::OP_QUERY, 0, 0, 0, 0, 65535, 65535, 0, 0, 0, 0, 0));
    // Pixel while frozen, then an inverted query box
    dir_rows.push_back(make_row(rbo_pkg::OP_ADD, 100, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(rbo_pkg::OP_QUERY, 0, 0, 10, 10, 5, 5, 1, 0, 0, 0, 0));
    dir_rows.push_back(make_row(rbo_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Single pixel at (1,1): widened box spans 8..24 on both axes
    dir_rows.push_back(make_row(rbo_pkg::OP_ADD, 16, 16, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Zero-width intersection still counts as overlap
    dir_rows.push_back(make_row(rbo_pkg::OP_QUERY, 0, 0, 24, 0, 40, 40, 1, 0, 0, 0, 1));
    // Zero-area query box: the min-area divisor is zero
    dir_rows.push_back(make_row(rbo_pkg::OP_QUERY, 0, 0, 16, 16, 16, 16, 1, 0, 0, 0, 1));
    // Query equal to the widened box: both ratios are one
    dir_rows.push_back(make_row(rbo_pkg::OP_QUERY, 0, 0, 8, 8, 24, 24, 1,
                                RATIO_ONE, RATIO_ONE, 0, 1));
    dir_rows.push_back(make_row(rbo_pkg::OP_QUERY, 0, 0, 100, 100, 200, 200, 1, 0, 0, 0, 0));
    dir_rows.push_back(make_row(rbo_pkg::OP_QUERY, 0, 0, 0, 0, 32, 20, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(rbo_pkg::OP_CLEAR, 65535, 65535, 65535, 65535, 65535, 65535,
                                0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(rbo_pkg::OP_QUERY, 65535, 65535, 65535, 65535, 65535, 65535,
                                1, 0, 0, 1, 0));
    dir_rows.push_back(make_row(rbo_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(rbo_pkg::OP_QUERY, 0, 0, 0, 0, 65535, 65535, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(rbo_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(rbo_pkg::OP_ADD, 65535, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(rbo_pkg::OP_ADD, 65500, 40, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(rbo_pkg::OP_QUERY, 0, 0, 65000, 0, 65535, 65535,
                                0, 0, 0, 0, 0));
    dir_rows.push_back(make_row(rbo_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    // Hold reset, then release it on a falling clock edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].res);

    // Random episodes: clear, a cluster of pixels, queries mostly near the box; else noise
    rand_start = useful_count;
    while (useful_count - rand_start < RANDOM_ITEMS) begin
      calm = (useful_count - rand_start) >= RANDOM_ITEMS - CALM_ITEMS;
      if ($urandom_range(0, 99) < 85) begin
        req = '0;
        req.op = rbo_pkg::OP_CLEAR;
        req.px = CW'($urandom);
        req.qby = CW'($urandom);
        send_request(req, 1'b0, '0);
        spread = pick_spread();
        cx = $urandom_range(0, 65535);
        cy = $urandom_range(0, 65535);
        repeat ($urandom_range(1, 12)) begin
          req = overlap_req_t'({$urandom, $urandom, $urandom});
          req.op = rbo_pkg::OP_ADD;
          req.px = clamp_coord(cx + rand_off(spread));
          req.py = clamp_coord(cy + rand_off(spread));
          send_request(req, 1'b0, '0);
        end
        repeat ($urandom_range(1, 3)) begin
          req = overlap_req_t'({$urandom, $urandom, $urandom});
          req.op = rbo_pkg::OP_QUERY;
          mode = $urandom_range(0, 9);
          qspread = pick_spread();
          if (mode != 0) begin
            req.qlx = clamp_coord(int'(region_left) + rand_off(qspread));
            req.qty = clamp_coord(int'(region_top) + rand_off(qspread));
            req.qrx = clamp_coord(int'(region_right) + rand_off(qspread));
            req.qby = clamp_coord(int'(region_bottom) + rand_off(qspread));
          end
          // Invert the box now and then
          if (mode == 1) begin
            swap = req.qlx;
            req.qlx = req.qrx;
            req.qrx = swap;
          end
          send_request(req, 1'b0, '0);
          // Late pixel on a frozen box
          if ($urandom_range(0, 3) == 0) begin
            req.op = rbo_pkg::OP_ADD;
            send_request(req, 1'b0, '0);
          end
        end
      end else begin
        // Noise: any code, any data
        req = overlap_req_t'({$urandom, $urandom, $urandom, $urandom});
        send_request(req, 1'b0, '0);
      end
    end
    s_axis_tvalid = 1'b0;

    // Drain outstanding results, then watch for strays
    while (ratio_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    fail_count += ratio_expect_q.size();

    $display("Sent %0d effective requests; %0d query results came back,", useful_count,
             results_seen, " %0d with overlapping boxes and %0d on an empty region.",
             overlap_hits, empty_hits);
    $display("Mismatches or stray results: %0d", fail_count);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/rbo_pkg.sv
rtl/rbo_ctrl.sv
rtl/rbo_datapath.sv
rtl/region_bbox_overlap_ratio.sv
rtl/rbo_checker.sv
tb/region_bbox_overlap_ratio_tb.sv
